[src/tgarle_pkg.sv]
package tgarle_pkg;

  // column plus run length, and the effective row width (zero width means 65536)
  localparam int unsigned PosW = 17;
  localparam int unsigned CntW = $clog2(PosW + 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_RLE_ENABLE   = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_GRAY8  = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_BGR24  = 2'd2,
    FMT_BGRA32 = 2'd3
  } pix_fmt_e;

  typedef struct packed {
    logic            start;
    logic [PosW-1:0] dividend;
    logic [PosW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PosW-1:0] quotient;
    logic [PosW-1:0] remainder;
  } div_rsp_t;

endpackage

[src/tgarle_div.sv]
module tgarle_div
  import tgarle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] rem_q, rem_d;
  logic [PosW-1:0] dvd_q, dvd_d;
  logic [PosW-1:0] quo_q, quo_d;
  logic [PosW-1:0] dsr_q, dsr_d;
  logic [PosW:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[PosW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(PosW);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      quo_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[PosW-2:0], 1'b0};
        if (trial >= {1'b0, dsr_q}) begin
          rem_d = PosW'(trial - {1'b0, dsr_q});
          quo_d = {quo_q[PosW-2:0], 1'b1};
        end else begin
          rem_d = trial[PosW-1:0];
          quo_d = {quo_q[PosW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = busy_q && (cnt_q == '0);
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

[src/tga_rle_gray_decoder.sv]
// targa image data decoder producing gray depth runs
//
// input stream: one image data byte per transfer on s_axis (tdata = the byte,
// tuser = frame start, which clears packet, partial pixel, column and row
// before the byte is used). with rle on, header bytes open repeat or literal
// packets and give no result. each completed pixel gives one result transfer
// on m_axis: gray value, run length, start column and start row.
// configuration: cfg channel writes pixel format, rle enable and image width
// by register index; it is always ready and must only be used while idle.
// path: a byte goes into the input register, then decode writes the result
// into the output register. throughput: one byte per cycle while m_axis does not stall and no division runs.
// a run that would carry the column over more than one row end (narrow
// images, or a width that shrank mid-stream) goes through a bit-serial
// divider of 17 steps; the next byte waits until the divider is done.
// reset: registers go to their defaults (format 0, rle off, width 1), no
// transfer pending. when m_axis stalls, one result waits in the output
// register and one byte in the input register, then s_axis_tready drops.
module tga_rle_gray_decoder
  import tgarle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // byte stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]          s_axis_tuser_i,   // [0] frame_start
  // depth runs out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [47:0]         m_axis_tdata_o    // [7:0] depth_value, [15:8] repeat_count,
                                                // [31:16] start_column, [47:32] start_row
);

  // configuration registers
  pix_fmt_e    fmt_q;
  logic        rle_q;
  logic [15:0] width_q;

  // input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_first_q;

  // stream state
  logic        hdr_q, hdr_d;
  logic [7:0]  left_q, left_d;
  logic        rep_q, rep_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [23:0] asm_q, asm_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q, out_data_d;

  logic        fire;
  logic        has_result;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // state after an optional frame clear
  logic        hdr_e, rep_e;
  logic [7:0]  left_e;
  logic [1:0]  bidx_e;
  logic [23:0] asm_e, asm_n;
  logic [15:0] col_e, row_e;

  logic [7:0]  r8, g8, b8, depth;
  logic [12:0] gray_sum;
  logic [7:0]  count;
  logic [PosW-1:0] wid, pos, pos_sub;
  logic [PosW:0]   wid2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_GRAY8;
      rle_q   <= 1'b0;
      width_q <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_FORMAT: fmt_q   <= pix_fmt_e'(cfg_data_i[1:0]);
        CFG_RLE_ENABLE:   rle_q   <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode fires when a byte is held, the result slot frees up and no
  // column wrap division is running
  assign fire = in_valid_q && (!out_valid_q || m_axis_tready_i) && !div_rsp.busy;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i[0];
    end
  end

  // frame start clears everything before the byte is used
  always_comb begin
    hdr_e  = in_first_q ? 1'b1  : hdr_q;
    rep_e  = in_first_q ? 1'b0  : rep_q;
    left_e = in_first_q ? 8'd0  : left_q;
    bidx_e = in_first_q ? 2'd0  : bidx_q;
    asm_e  = in_first_q ? 24'd0 : asm_q;
    col_e  = in_first_q ? 16'd0 : col_q;
    row_e  = in_first_q ? 16'd0 : row_q;
  end

  // byte lands in the partial pixel; a fourth byte (alpha) is dropped
  always_comb begin
    case (bidx_e)
      2'd0:    asm_n = asm_e | {16'd0, in_byte_q};
      2'd1:    asm_n = asm_e | {8'd0, in_byte_q, 8'd0};
      2'd2:    asm_n = asm_e | {in_byte_q, 16'd0};
      default: asm_n = asm_e;
    endcase
  end

  // gray value: (11r + 16g + 5b) >> 5
  always_comb begin
    if (fmt_q == FMT_RGB555) begin
      b8 = {3'd0, asm_n[4:0]};
      g8 = {3'd0, asm_n[9:8], asm_n[7:5]};
      r8 = {3'd0, asm_n[14:10]};
    end else begin
      b8 = asm_n[7:0];
      g8 = asm_n[15:8];
      r8 = asm_n[23:16];
    end
    gray_sum = 13'(r8) * 13'd11 + {1'b0, g8, 4'd0} + 13'(b8) * 13'd5;
    depth    = (fmt_q == FMT_GRAY8) ? asm_n[7:0] : gray_sum[12:5];
  end

  // effective width, zero meaning 65536
  assign wid  = (width_q == 16'd0) ? {1'b1, 16'd0} : {1'b0, width_q};
  assign wid2 = {wid, 1'b0};

  always_comb begin
    hdr_d       = hdr_q;
    rep_d       = rep_q;
    left_d      = left_q;
    bidx_d      = bidx_q;
    asm_d       = asm_q;
    col_d       = col_q;
    row_d       = row_q;
    has_result  = 1'b0;
    count       = 8'd1;
    pos         = {1'b0, col_e} + PosW'(count);
    pos_sub     = pos - wid;
    div_req     = '0;

    if (fire) begin
      hdr_d  = hdr_e;
      rep_d  = rep_e;
      left_d = left_e;
      bidx_d = bidx_e;
      asm_d  = asm_e;
      col_d  = col_e;
      row_d  = row_e;
      if (rle_q && (hdr_e || left_e == 8'd0)) begin
        // packet header
        rep_d  = in_byte_q[7];
        left_d = in_byte_q[7] ? (in_byte_q - 8'd127) : (in_byte_q + 8'd1);
        hdr_d  = 1'b0;
      end else if (bidx_e < fmt_q) begin
        asm_d  = asm_n;
        bidx_d = bidx_e + 2'd1;
      end else begin
        // pixel complete
        has_result = 1'b1;
        asm_d      = '0;
        bidx_d     = 2'd0;
        if (rle_q) begin
          if (rep_e) begin
            count  = left_e;
            left_d = 8'd0;
          end else begin
            left_d = left_e - 8'd1;
          end
          if (left_d == 8'd0) begin
            hdr_d = 1'b1;
          end
        end
        pos     = {1'b0, col_e} + PosW'(count);
        pos_sub = pos - wid;
        if (pos < wid) begin
          col_d = pos[15:0];
        end else if ({1'b0, pos} < wid2) begin
          col_d = pos_sub[15:0];
          row_d = row_e + 16'd1;
        end else begin
          // wraps over several rows: hand it to the divider
          div_req.start    = 1'b1;
          div_req.dividend = pos;
          div_req.divisor  = wid;
        end
      end
    end else if (div_rsp.done) begin
      col_d = div_rsp.remainder[15:0];
      row_d = row_q + div_rsp.quotient[15:0];
    end
  end

  tgarle_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (fire && has_result) begin
      out_valid_d = 1'b1;
      out_data_d  = {row_e, col_e, count, depth};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hdr_q       <= 1'b1;
      rep_q       <= 1'b0;
      left_q      <= 8'd0;
      bidx_q      <= 2'd0;
      asm_q       <= 24'd0;
      col_q       <= 16'd0;
      row_q       <= 16'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      hdr_q       <= hdr_d;
      rep_q       <= rep_d;
      left_q      <= left_d;
      bidx_q      <= bidx_d;
      asm_q       <= asm_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[tb/depth_run_checker.sv]
module depth_run_checker
  import tgarle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [7:0]          s_tdata_i,   // [7:0] data_byte
  input  logic [0:0]          s_tuser_i,   // [0] frame_start
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [47:0]         m_tdata_i,   // [7:0] depth, [15:8] count, [31:16] column,
                                           // [47:32] row
  output int                  fail_count_o,
  output int                  open_runs_o
);

  // same bit order as m_tdata, depth in the low byte
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  count;
    logic [7:0]  depth;
  } depth_run_t;

  pix_fmt_e    fmt_q;
  logic        rle_q;
  logic [15:0] width_q;
  logic        want_header_q;
  logic [7:0]  pixels_left_q;
  logic        repeat_q;
  logic [1:0]  byte_idx_q;
  logic [23:0] assembly_q;
  logic [15:0] column_q;
  logic [15:0] row_q;

  depth_run_t  runs_due[$];

  initial begin
    fail_count_o = 0;
    open_runs_o  = 0;
  end

  task automatic report(string msg);
    $display("%0t depth_run_checker: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void restart_frame();
    want_header_q = 1'b1;
    pixels_left_q = '0;
    repeat_q      = 1'b0;
    byte_idx_q    = '0;
    assembly_q    = '0;
    column_q      = '0;
    row_q         = '0;
  endfunction

  function automatic logic [7:0] gray_level(pix_fmt_e fmt, logic [23:0] px);
    logic [7:0]  r, g, b;
    int unsigned mix;
    case (fmt)
      FMT_GRAY8: begin
        return px[7:0];
      end
      FMT_RGB555: begin
        b = {3'b000, px[4:0]};
        g = {3'b000, px[9:8], px[7:5]};
        r = {3'b000, px[14:10]};
      end
      default: begin
        b = px[7:0];
        g = px[15:8];
        r = px[23:16];
      end
    endcase
    mix = 11 * r + 16 * g + 5 * b;
    return 8'(mix >> 5);
  endfunction

  task automatic take_byte(logic [7:0] d, logic frame);
    depth_run_t  run;
    int unsigned span, pos;
    if (frame) restart_frame();
    // packet header: opens a repeat or literal packet, no run
    if (rle_q && (want_header_q || pixels_left_q == 8'd0)) begin
      repeat_q      = d[7];
      pixels_left_q = d[7] ? 8'(d - 8'd127) : 8'(d + 8'd1);
      want_header_q = 1'b0;
      return;
    end
    if (byte_idx_q != 2'd3) assembly_q = assembly_q | (24'(d) << (8 * byte_idx_q));
    if (byte_idx_q < fmt_q) begin
      byte_idx_q = byte_idx_q + 2'd1;
      return;
    end
    run.depth  = gray_level(fmt_q, assembly_q);
    byte_idx_q = '0;
    assembly_q = '0;
    run.count  = 8'd1;
    if (rle_q) begin
      if (repeat_q) begin
        run.count     = pixels_left_q;
        pixels_left_q = '0;
      end else begin
        pixels_left_q = pixels_left_q - 8'd1;
      end
      if (pixels_left_q == 8'd0) want_header_q = 1'b1;
    end
    run.column = column_q;
    run.row    = row_q;
    span       = (width_q == 16'd0) ? 65536 : width_q;
    pos        = column_q + run.count;
    row_q      = 16'(row_q + pos / span);
    column_q   = 16'(pos % span);
    runs_due.push_back(run);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_run(logic [47:0] raw);
    depth_run_t got, want;
    got = raw;
    if (runs_due.size() == 0) begin
      report($sformatf("run with none pending: depth %0d count %0d column %0d row %0d",
                       got.depth, got.count, got.column, got.row));
      return;
    end
    want = runs_due.pop_front();
    check_field("depth_value", got.depth, want.depth);
    check_field("repeat_count", got.count, want.count);
    check_field("start_column", got.column, want.column);
    check_field("start_row", got.row, want.row);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   = FMT_GRAY8;
      rle_q   = 1'b0;
      width_q = 16'd1;
      restart_frame();
      runs_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PIXEL_FORMAT: fmt_q = pix_fmt_e'(cfg_data_i[1:0]);
          CFG_RLE_ENABLE:   rle_q = cfg_data_i[0];
          CFG_IMAGE_WIDTH:  width_q = cfg_data_i;
          default: ;
        endcase
      end
      // a run never leaves in the same cycle as its byte, so retire before predicting
      if (m_tvalid_i && m_tready_i) check_run(m_tdata_i);
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i, s_tuser_i[0]);
    end
    open_runs_o = runs_due.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top
  import tgarle_pkg::*;
();

  // cycles without any transfer before the run is declared hung
  localparam int unsigned QuietLimit = 2000;
  // cycles allowed for bytes still inside the block (pipeline plus divider)
  localparam int unsigned DrainCycles = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  // configuration write channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CFG_PIXEL_FORMAT;
  logic [CfgDataW-1:0] cfg_data = '0;

  // byte stream into the decoder
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = '0;   // [7:0] data_byte
  logic [0:0]          in_frame = '0;  // [0] frame_start

  // depth runs out of the decoder
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [47:0]         out_run;        // [7:0] depth, [15:8] count, [31:16] column,
                                       // [47:32] row

  int                  mismatches;
  int                  open_runs;

  // pacing in percent of cycles
  int unsigned         sender_idle_pct = 0;
  int unsigned         sink_stall_pct = 0;

  // mirror of the registers, so packets are built for the current format
  pix_fmt_e            cur_fmt = FMT_GRAY8;
  logic                cur_rle = 1'b0;
  int unsigned         bytes_sent = 0;
  int unsigned         quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tga_rle_gray_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),
    .s_axis_tuser_i  (in_frame),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_run)
  );

  depth_run_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (in_valid),
    .s_tready_i   (in_ready),
    .s_tdata_i    (in_byte),
    .s_tuser_i    (in_frame),
    .m_tvalid_i   (out_valid),
    .m_tready_i   (out_ready),
    .m_tdata_i    (out_run),
    .fail_count_o (mismatches),
    .open_runs_o  (open_runs)
  );

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // hang detection: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both a little
  task automatic set_pace(int unsigned mode);
    case (mode)
      1: begin
        sender_idle_pct = 72;
        sink_stall_pct  = 0;
      end
      2: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 72;
      end
      3: begin
        sender_idle_pct = 14;
        sink_stall_pct  = 14;
      end
      default: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
      end
    endcase
  endtask

  // one byte transfer; tvalid stays high on return so back-to-back bytes
  // follow without a gap
  task automatic send_byte(logic [7:0] value, logic frame);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    in_frame <= frame;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // hold the stream until every predicted run is out, then let the
  // pipeline and the divider run dry so registers can be written safely
  task automatic settle();
    in_valid <= 1'b0;
    while (open_runs != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // writes the spare index too; the decoder must ignore it
  task automatic configure(pix_fmt_e fmt, logic rle, logic [15:0] width);
    cfg_idx_e    order [4];
    logic [15:0] value [4];
    order = '{CFG_UNUSED, CFG_PIXEL_FORMAT, CFG_RLE_ENABLE, CFG_IMAGE_WIDTH};
    // unused upper bits of the narrow registers carry random junk
    value = '{16'($urandom), 16'({$urandom_range(16383), 2'(fmt)}),
              16'({$urandom_range(32767), rle}), width};
    foreach (order[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_fmt = fmt;
    cur_rle = rle;
  endtask

  task automatic send_pixel(logic frame);
    for (int i = 0; i <= int'(cur_fmt); i++) begin
      send_byte(8'($urandom), (i == 0) ? frame : 1'b0);
    end
  endtask

  // a well-formed packet with random content; plain pixel when rle is off
  task automatic send_packet(logic frame);
    int unsigned n;
    if (!cur_rle) begin
      send_pixel(frame);
      return;
    end
    if ($urandom_range(1) == 1) begin
      // repeat packet: one pixel covers n positions
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      send_byte(8'(127 + n), frame);
      send_pixel(1'b0);
    end else begin
      // literal packet: long ones are rare to keep the byte count down
      n = ($urandom_range(29) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      send_byte(8'(n - 1), frame);
      repeat (n) send_pixel(1'b0);
    end
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'($urandom_range(2, 8));
      2: return 16'($urandom_range(9, 300));
      3: return 16'hFFFF;
      4: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int unsigned mode);
    int unsigned start;
    logic        first;
    settle();
    set_pace(mode);
    configure(pix_fmt_e'($urandom_range(3)), 1'($urandom_range(1)), pick_width());
    // mostly a clean frame start; otherwise packet state carries over
    first = ($urandom_range(9) < 7);
    start = bytes_sent;
    while (bytes_sent - start < 40) begin
      case ($urandom_range(19))
        0: send_byte(8'($urandom), 1'($urandom));  // noise, breaks alignment
        1: send_packet(1'b1);                      // restart in mid frame
        default: send_packet(first);
      endcase
      first = 1'b0;
    end
    // leave a partial pixel or packet open across the next register writes
    repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: register defaults, gray bytes at the extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);

    // 555 with rle and zero width (acts as 65536): longest repeat packet,
    // shortest repeat, shortest literal, channel maxima
    settle();
    configure(FMT_RGB555, 1'b1, 16'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h03, 1'b0);

    // 24-bit at the widest row: a literal packet of two pixels
    settle();
    configure(FMT_BGR24, 1'b1, 16'hFFFF);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);

    // 32-bit on a narrow row, then a pixel cut short by a format change:
    // the next byte completes it under gray while the packet state is kept
    settle();
    configure(FMT_BGRA32, 1'b1, 16'd3);
    send_byte(8'h81, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    settle();
    configure(FMT_GRAY8, 1'b0, 16'd3);
    send_byte(8'h56, 1'b0);

    // random phases cycle through the pacing modes
    for (int ph = 0; ph < 4; ph++) random_phase(ph % 4);

    // row overflow: one row per position, 128 rows per run, past 65536 rows
    settle();
    set_pace(3);
    configure(FMT_GRAY8, 1'b1, 16'd1);
    for (int i = 0; i < 520; i++) begin
      send_byte(8'hFF, (i == 0));
      send_byte(8'($urandom), 1'b0);
    end

    for (int ph = 4; ph < 8; ph++) random_phase(ph % 4);

    // drain, then give the verdict
    settle();
    if (mismatches == 0 && open_runs == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
